### sv/rle565_pkg.sv
package rle565_pkg;

   // Field widths
   localparam int unsigned ChannelWidth = 8;
   localparam int unsigned WordWidth    = 16;

   // Output queue depth: room for two words whenever at most one is held
   localparam int unsigned QueueDepth = 3;
   localparam int unsigned QueueIndexWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   // Rounding constants of the 8-bit to 5/6-bit conversion
   localparam logic [7:0]  RedBlueScale  = 8'd249;
   localparam logic [15:0] RedBlueOffset = 16'd1014;
   localparam logic [7:0]  GreenScale    = 8'd253;
   localparam logic [15:0] GreenOffset   = 16'd505;
   localparam logic [5:0]  GreenMask     = 6'h3F;
   localparam logic [4:0]  RedBlueMask   = 5'h1F;

   // Run counter limit: a count that reaches it is flushed at once
   localparam logic [WordWidth-1:0] CountLimit = 16'hFFFF;

   // Mode register values
   localparam logic ModeRaw = 1'b0;
   localparam logic ModeRun = 1'b1;

   // Word kinds
   localparam logic KindColour = 1'b0;
   localparam logic KindCount  = 1'b1;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic [ChannelWidth-1:0] red;
      logic [ChannelWidth-1:0] green;
      logic [ChannelWidth-1:0] blue;
      logic                    final_pixel;
   } pixel_type;

   typedef struct packed {
      word_type word;
      logic     word_kind;
      logic     end_of_burst;
   } result_type;

   // Words pushed into the output queue for one processed item
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Output queue status seen by the encoder core
   typedef struct packed {
      logic                       room;
      logic [QueueCountWidth-1:0] fill;
   } queue_status_type;

   // Round an 8-bit RGB pixel to an RGB565 colour word
   function automatic word_type to_rgb565(input logic [ChannelWidth-1:0] red,
                                          input logic [ChannelWidth-1:0] green,
                                          input logic [ChannelWidth-1:0] blue);
      logic [15:0] red_sum;
      logic [15:0] green_sum;
      logic [15:0] blue_sum;
      red_sum   = {8'd0, red} * {8'd0, RedBlueScale} + RedBlueOffset;
      green_sum = {8'd0, green} * {8'd0, GreenScale} + GreenOffset;
      blue_sum  = {8'd0, blue} * {8'd0, RedBlueScale} + RedBlueOffset;
      return {red_sum[15:11] & RedBlueMask, green_sum[15:10] & GreenMask,
              blue_sum[15:11] & RedBlueMask};
   endfunction

endpackage

### sv/rle565_pixel_if.sv
interface rle565_pixel_if import rle565_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/rle565_word_if.sv
interface rle565_word_if import rle565_pkg::*; ();
   logic       valid;
   logic       ready;
   result_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/rle565_core.sv
module rle565_core import rle565_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pixel_valid,
   output logic             pixel_ready,
   input  pixel_type        pixel,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   input  queue_status_type status,
   output push_type         push
);

   logic      mode_ff, mode_in;
   logic      held_ff, held_in;
   pixel_type pixel_ff;
   word_type  previous_ff, previous_in;
   word_type  count_ff, count_in;
   logic      first_ff, first_in;

   logic       fire;
   word_type   colour;
   word_type   count_next;
   word_type   increment;
   logic       same;
   logic [1:0] emitted;
   result_type slot [2];

   // Process the held item when the queue has room for two words
   assign fire        = held_ff && status.room;
   assign pixel_ready = !held_ff || status.room;

   assign colour    = to_rgb565(pixel_ff.red, pixel_ff.green, pixel_ff.blue);
   assign same      = (colour == previous_ff);
   assign increment = WordWidth'({1'b0, count_ff} + 17'd1);

   // Decide the words of this item and the next run state
   always_comb begin
      previous_in = previous_ff;
      first_in    = first_ff;
      count_next  = count_ff;
      emitted     = 2'd0;
      slot[0]     = '{word: colour, word_kind: KindColour, end_of_burst: 1'b0};
      slot[1]     = '{word: colour, word_kind: KindColour, end_of_burst: 1'b0};
      if (mode_ff == ModeRaw) begin
         emitted = 2'd1;
      end else begin
         if (first_ff) begin
            emitted  = 2'd1;
            first_in = 1'b0;
         end else if (count_ff == '0) begin
            if (same) begin
               count_next = WordWidth'(1);
            end
            emitted = 2'd1;
         end else if (same) begin
            if (increment == CountLimit) begin
               slot[0]    = '{word: CountLimit, word_kind: KindCount, end_of_burst: 1'b0};
               emitted    = 2'd1;
               count_next = '0;
            end else begin
               count_next = increment;
            end
         end else begin
            slot[0]    = '{word: count_ff, word_kind: KindCount, end_of_burst: 1'b0};
            emitted    = 2'd2;
            count_next = '0;
         end
         previous_in = colour;
         // Flush an open run on the last pixel of the image
         if (pixel_ff.final_pixel) begin
            if (count_next != '0 && emitted != 2'd2) begin
               if (emitted == 2'd0) begin
                  slot[0] = '{word: count_next, word_kind: KindCount, end_of_burst: 1'b0};
                  emitted = 2'd1;
               end else begin
                  slot[1] = '{word: count_next, word_kind: KindCount, end_of_burst: 1'b0};
                  emitted = 2'd2;
               end
            end
            count_next = '0;
            first_in   = 1'b1;
         end
      end
      // Mark the last word of the burst
      if (emitted == 2'd1) begin
         slot[0].end_of_burst = 1'b1;
      end
      if (emitted == 2'd2) begin
         slot[1].end_of_burst = 1'b1;
      end
   end

   assign count_in = count_next;

   assign push.count  = fire ? emitted : 2'd0;
   assign push.first  = slot[0];
   assign push.second = slot[1];

   // Hold the input item until it is processed
   always_comb begin
      held_in = held_ff;
      if (fire) begin
         held_in = 1'b0;
      end
      if (pixel_valid && pixel_ready) begin
         held_in = 1'b1;
      end
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ModeRun;
         held_ff     <= 1'b0;
         previous_ff <= '0;
         count_ff    <= '0;
         first_ff    <= 1'b1;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         if (fire) begin
            previous_ff <= previous_in;
            count_ff    <= count_in;
            first_ff    <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_valid && pixel_ready) begin
         pixel_ff <= pixel;
      end
   end

endmodule

### sv/rle565_out_queue.sv
module rle565_out_queue import rle565_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   output queue_status_type status,
   output logic             result_valid,
   input  logic             result_ready,
   output result_type       result
);

   result_type                 entry_ff [QueueDepth];
   result_type                 entry_in [QueueDepth];
   logic [QueueCountWidth-1:0] fill_ff, fill_in;
   logic                       pop;
   logic [QueueCountWidth-1:0] base;
   logic [QueueCountWidth-1:0] base_next;

   assign result_valid = (fill_ff != '0);
   assign result       = entry_ff[0];
   assign pop          = result_valid && result_ready;

   assign status.room = (fill_ff <= QueueCountWidth'(QueueDepth - 2));
   assign status.fill = fill_ff;

   assign base      = fill_ff - QueueCountWidth'(pop);
   assign base_next = base + QueueCountWidth'(1);

   // Advance the queue on a pop, then append the pushed words
   always_comb begin
      for (int i = 0; i < QueueDepth; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < QueueDepth - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
      end
      if (push.count != 2'd0 && base < QueueCountWidth'(QueueDepth)) begin
         entry_in[base[QueueIndexWidth-1:0]] = push.first;
      end
      if (push.count == 2'd2 && base_next < QueueCountWidth'(QueueDepth)) begin
         entry_in[base_next[QueueIndexWidth-1:0]] = push.second;
      end
      fill_in = base + QueueCountWidth'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

### sv/rgb565_run_length_encoder_unit.sv
// RGB565 run-length encoder. Each req item is one 8-bit RGB pixel, rounded to an
// RGB565 colour; each rsp item is a colour word (word_kind 0) or a run count word
// (word_kind 1), with end_of_burst on the last word a pixel causes. csr_write_data
// selects raw mode (0, one colour word per pixel) or run mode (1, the reset value);
// write it only while the block is idle. The block takes one pixel per cycle unless
// stalled: a pixel is registered, encoded once the queue has room for two words, and
// its words enter a three-entry output queue. A pixel that yields two words can hold
// up the next pixel, since the queue drains one word per cycle; a pixel inside a run
// yields none. Backpressure on rsp stalls req once the queue holds two words and a
// pixel is waiting to be encoded.
module rgb565_run_length_encoder_unit import rle565_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rle565_pixel_if.sink  req,
   rle565_word_if.source rsp,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   push_type         push;
   queue_status_type status;

   // Encode pixels against the run state
   rle565_core core_u (
      .clock            (clock),
      .reset            (reset),
      .pixel_valid      (req.valid),
      .pixel_ready      (req.ready),
      .pixel            (req.payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .push             (push)
   );

   // Buffer result words towards the sink
   rle565_out_queue queue_u (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .status       (status),
      .result_valid (rsp.valid),
      .result_ready (rsp.ready),
      .result       (rsp.payload)
   );

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      status.fill <= QueueCountWidth'(QueueDepth))
      else $error("output queue overfilled");

   // Words are only pushed when there is room for two
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> status.room)
      else $error("push without room");

   // At most two words per pixel
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two words for one pixel");

   // A run count word is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.word_kind == KindCount |-> rsp.payload.word != '0)
      else $error("zero run count emitted");

endmodule

### sim/rgb565_run_length_encoder_unit_tb.sv
module rgb565_run_length_encoder_unit_tb;
   import rle565_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned SettleCycles  = 6;
   localparam int unsigned MaxPrinted    = 40;
   localparam logic [15:0] RunCountLimit = 16'hFFFF;

   // Predicts the words of every accepted pixel and checks the words that come out
   class rle_word_scoreboard;
      logic        compression_mode;
      word_type    last_colour;
      logic [15:0] run_length;
      logic        new_image;
      result_type  expected_words[$];
      int unsigned failures;

      function new();
         compression_mode = ModeRun;
         last_colour      = '0;
         run_length       = '0;
         new_image        = 1'b1;
         failures         = 0;
      endfunction

      // Round 8-bit channels to 5/6/5 bits with the multiply-add-shift formulas
      function word_type pack565(pixel_type p);
         logic [15:0] r_sum;
         logic [15:0] g_sum;
         logic [15:0] b_sum;
         r_sum = p.red * 16'd249 + 16'd1014;
         g_sum = p.green * 16'd253 + 16'd505;
         b_sum = p.blue * 16'd249 + 16'd1014;
         return {r_sum[15:11], g_sum[15:10], b_sum[15:11]};
      endfunction

      function result_type make_word(word_type w, logic kind);
         result_type r;
         r.word         = w;
         r.word_kind    = kind;
         r.end_of_burst = 1'b0;
         return r;
      endfunction

      // Advance the encoder state by one pixel and queue the words it causes
      function void note_pixel(pixel_type p);
         result_type burst[$];
         word_type   colour;
         colour = pack565(p);
         if (compression_mode == ModeRaw) begin
            burst.push_back(make_word(colour, KindColour));
         end else begin
            if (new_image) begin
               burst.push_back(make_word(colour, KindColour));
               new_image = 1'b0;
            end else if (run_length == 0) begin
               if (colour == last_colour)
                  run_length = 16'd1;
               burst.push_back(make_word(colour, KindColour));
            end else if (colour == last_colour) begin
               run_length = run_length + 16'd1;
               // flush a saturated count at once
               if (run_length == RunCountLimit) begin
                  burst.push_back(make_word(RunCountLimit, KindCount));
                  run_length = '0;
               end
            end else begin
               burst.push_back(make_word(run_length, KindCount));
               burst.push_back(make_word(colour, KindColour));
               run_length = '0;
            end
            last_colour = colour;
            // last pixel of the image closes any open run
            if (p.final_pixel) begin
               if (run_length != 0 && burst.size() < 2)
                  burst.push_back(make_word(run_length, KindCount));
               run_length = '0;
               new_image  = 1'b1;
            end
         end
         if (burst.size() > 0)
            burst[burst.size() - 1].end_of_burst = 1'b1;
         foreach (burst[i])
            expected_words.push_back(burst[i]);
      endfunction

      task report(input string what, input logic [15:0] got, input logic [15:0] want);
         if (failures < MaxPrinted)
            $display("mismatch: %s got %h expected %h", what, got, want);
         failures++;
      endtask

      // Compare one output word, field by field, with the oldest expectation
      task check_word(input result_type got);
         result_type want;
         if (expected_words.size() == 0) begin
            report("unexpected word", got.word, '0);
            return;
         end
         want = expected_words.pop_front();
         if (got.word !== want.word)
            report("word", got.word, want.word);
         if (got.word_kind !== want.word_kind)
            report("word_kind", 16'(got.word_kind), 16'(want.word_kind));
         if (got.end_of_burst !== want.end_of_burst)
            report("end_of_burst", 16'(got.end_of_burst), 16'(want.end_of_burst));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   rle565_pixel_if pixel_ch ();
   rle565_word_if  word_ch ();

   rle_word_scoreboard scoreboard = new();

   int unsigned hold_off_cycles;
   int unsigned steady_items;
   int unsigned quiet_cycles;

   rgb565_run_length_encoder_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (pixel_ch),
      .rsp              (word_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Note accepted pixels and check accepted words
   always @(posedge clock) begin
      if (!reset) begin
         if (pixel_ch.valid && pixel_ch.ready)
            scoreboard.note_pixel(pixel_ch.payload);
         if (word_ch.valid && word_ch.ready)
            scoreboard.check_word(word_ch.payload);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (pixel_ch.valid && pixel_ch.ready) || (word_ch.valid && word_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic pixel_type make_pixel(int unsigned r, int unsigned g, int unsigned b,
                                            logic last);
      pixel_type p;
      p.red         = r[7:0];
      p.green       = g[7:0];
      p.blue        = b[7:0];
      p.final_pixel = last;
      return p;
   endfunction

   function automatic pixel_type rand_pixel();
      return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), 1'b0);
   endfunction

   // Offer one pixel and hold it until the block takes it
   task automatic offer(input pixel_type p);
      int unsigned gap;
      if (steady_items > 0) begin
         steady_items--;
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      pixel_ch.valid   <= 1'b1;
      pixel_ch.payload <= p;
      @(posedge clock);
      while (!pixel_ch.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected word has come out
   task automatic drain(input int unsigned settle);
      pixel_ch.valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain(SettleCycles);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scoreboard.compression_mode = mode;
   endtask

   // Runs of equal colours with random content, a little noise and broken runs
   task automatic random_phase(input int unsigned items, input int unsigned pause_at);
      pixel_type   palette[4];
      pixel_type   p;
      pixel_type   q;
      int unsigned sent;
      int unsigned len;
      int unsigned roll;
      int unsigned k;
      foreach (palette[i])
         palette[i] = rand_pixel();
      sent = 0;
      while (sent < items) begin
         if (pause_at != 0 && sent >= pause_at) begin
            drain(0);
            pause_at = 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            p = rand_pixel();
            p.final_pixel = $urandom_range(0, 1);
            offer(p);
            sent++;
         end else begin
            p = (roll < 40) ? palette[$urandom_range(0, 3)] : rand_pixel();
            roll = $urandom_range(0, 99);
            if (roll < 50)
               len = 1;
            else if (roll < 85)
               len = $urandom_range(2, 6);
            else
               len = $urandom_range(7, 40);
            for (k = 0; k < len; k++) begin
               q = p;
               // nudge the low bits: the colour may or may not change
               if ($urandom_range(0, 4) == 0) begin
                  q.red[0]  = ~q.red[0];
                  q.blue[0] = ~q.blue[0];
               end
               q.final_pixel = ($urandom_range(0, 39) == 0) ||
                               (k == len - 1 && $urandom_range(0, 5) == 0);
               offer(q);
               sent++;
            end
         end
      end
   endtask

   // Receiver: random stalls, with one long hold-off on request
   initial begin : receiver
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = pick_gap();
         end
         if (stall != 0) begin
            word_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         word_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin : stimulus
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      pixel_ch.valid   = 1'b0;
      pixel_ch.payload = '0;
      word_ch.ready    = 1'b0;
      hold_off_cycles  = 0;
      steady_items     = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: run mode from reset
      offer(make_pixel(0, 0, 0, 1'b0));         // first pixel of an image
      offer(make_pixel(1, 0, 0, 1'b0));         // same colour: opens a run
      offer(make_pixel(0, 0, 0, 1'b0));         // inside the run: count only
      offer(make_pixel(255, 255, 255, 1'b0));   // closes the run: count then colour
      offer(make_pixel(255, 255, 255, 1'b1));   // opens a run and ends the image
      offer(make_pixel(255, 0, 255, 1'b0));
      offer(make_pixel(255, 0, 255, 1'b0));
      offer(make_pixel(255, 0, 255, 1'b0));
      offer(make_pixel(0, 255, 0, 1'b1));       // closes a run on the last pixel
      offer(make_pixel(0, 255, 0, 1'b0));
      offer(make_pixel(0, 255, 0, 1'b0));
      offer(make_pixel(0, 255, 0, 1'b1));       // last pixel inside a run: flush count
      offer(make_pixel(128, 64, 32, 1'b1));     // single-pixel image
      offer(make_pixel(128, 64, 32, 1'b0));
      offer(make_pixel(128, 64, 32, 1'b0));     // leave a run open

      // Raw mode: the open run stays pending
      write_mode(ModeRaw);
      offer(make_pixel(128, 64, 32, 1'b0));
      offer(make_pixel(10, 20, 30, 1'b1));
      offer(make_pixel(170, 85, 170, 1'b0));
      offer(make_pixel(85, 170, 85, 1'b0));

      // Back to run mode: the pending run resumes
      write_mode(ModeRun);
      offer(make_pixel(128, 64, 32, 1'b0));
      offer(make_pixel(1, 2, 3, 1'b0));
      offer(make_pixel(1, 2, 3, 1'b1));
      offer(make_pixel(170, 85, 170, 1'b0));
      offer(make_pixel(85, 170, 85, 1'b1));

      // Random phases across both modes
      write_mode(ModeRaw);
      random_phase(300, 0);

      // Long receiver hold-off while pixels keep coming
      write_mode(ModeRun);
      hold_off_cycles = 400;
      steady_items    = 150;
      random_phase(400, 0);
      steady_items = 0;

      write_mode(ModeRaw);
      random_phase(300, 150);

      write_mode(ModeRun);
      random_phase(600, 300);

      drain(8);
      if (scoreboard.failures == 0 && scoreboard.expected_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
